>>> src/gga_pfx_pkg.sv
// Shared constants and helpers for the GGA position field extractor.
package gga_pfx_pkg;

    // Sentence layout
    localparam int unsigned HDR_LEN  = 6;
    localparam int unsigned LAT_LEN  = 7;
    localparam int unsigned LON_LEN  = 8;
    localparam int unsigned LAT_W    = LAT_LEN * 8;
    localparam int unsigned LON_W    = LON_LEN * 8;
    localparam int unsigned COMMA_MAX = 6;

    // Field numbers, counted in commas seen
    localparam logic [2:0] FLD_LAT = 3'd2;
    localparam logic [2:0] FLD_NS  = 3'd3;
    localparam logic [2:0] FLD_LON = 3'd4;
    localparam logic [2:0] FLD_EW  = 3'd5;

    // Characters of interest
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_W      = 8'h57;

    // Header check: "$GPGGA" or "$GNGGA"; the talker letter may be P or N
    function automatic logic hdr_char_ok(input logic [2:0] pos, input logic [7:0] c);
        logic ok;
        begin
            case (pos)
                3'd0: ok = (c == CH_DOLLAR);
                3'd1: ok = (c == CH_G);
                3'd2: ok = (c == CH_P) || (c == CH_N);
                3'd3: ok = (c == CH_G);
                3'd4: ok = (c == CH_G);
                3'd5: ok = (c == CH_A);
                default: ok = 1'b1;
            endcase
            return ok;
        end
    endfunction

endpackage

>>> src/gga_position_field_extractor_unit.sv
// Top level of the GGA position field extractor: per-character parser and result register.
//
// Usage
//   Input channel: one sentence character per request on i_in_char, with
//   i_is_last marking the final character of the line. A request is taken at
//   a rising edge with i_in_valid high and o_in_stall low.
//   Output channel: one result per line, presented on o_out_valid together
//   with o_found and the captured latitude, longitude and hemisphere letters.
//   Payload fields read zero when o_found is low.
// Latency and throughput
//   One character per cycle while o_in_stall is low. The result of a line appears in the
//   cycle after its final character is taken. The per-character state update
//   and the found decision are combinational, between the parser registers and
//   the result register.
// Reset and stalls
//   i_rst_n (synchronous, active low) empties the result register and clears
//   the line state, ready for a new sentence. While a result is held and the
//   receiver stalls, o_in_stall is raised and no character is taken.
module gga_position_field_extractor_unit
    import gga_pfx_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_in_char,
    input  logic             i_is_last,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_found,
    output logic [LAT_W-1:0] o_lat_digits,
    output logic [7:0]       o_ns_letter,
    output logic [LON_W-1:0] o_lon_digits,
    output logic [7:0]       o_ew_letter
);

    // Line state
    logic [2:0]       r_pos, n_pos;
    logic             r_hdr_ok, n_hdr_ok;
    logic [2:0]       r_commas, n_commas;
    logic [3:0]       r_flen, n_flen;
    logic [LAT_W-1:0] r_lat, n_lat;
    logic [LON_W-1:0] r_lon, n_lon;
    logic [7:0]       r_ns, n_ns;
    logic [7:0]       r_ew, n_ew;
    logic             r_lat_done, n_lat_done;
    logic             r_lon_done, n_lon_done;
    logic             r_ended, n_ended;

    // Result register
    logic             r_out_valid;
    logic             r_found;
    logic [LAT_W-1:0] r_lat_q;
    logic [7:0]       r_ns_q;
    logic [LON_W-1:0] r_lon_q;
    logic [7:0]       r_ew_q;

    logic acc;
    logic load;
    logic found;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign acc        = i_in_valid && !o_in_stall;
    assign load       = acc && i_is_last;

    // Per-character update of the line state
    always_comb begin
        n_pos      = r_pos;
        n_hdr_ok   = r_hdr_ok;
        n_commas   = r_commas;
        n_flen     = r_flen;
        n_lat      = r_lat;
        n_lon      = r_lon;
        n_ns       = r_ns;
        n_ew       = r_ew;
        n_lat_done = r_lat_done;
        n_lon_done = r_lon_done;
        n_ended    = r_ended;
        if (!r_ended) begin
            if (i_in_char == CH_NUL) begin
                n_ended = 1'b1;
            end else begin
                // header compare, saturating at the header length
                if (r_pos < 3'(HDR_LEN)) begin
                    if (!hdr_char_ok(r_pos, i_in_char)) begin
                        n_hdr_ok = 1'b0;
                    end
                    n_pos = r_pos + 3'd1;
                end
                // field capture
                if (i_in_char == CH_COMMA) begin
                    if (r_commas < 3'(COMMA_MAX)) begin
                        n_commas = r_commas + 3'd1;
                    end
                    n_flen = 4'd0;
                end else begin
                    case (r_commas)
                        FLD_LAT: begin
                            if (r_flen < 4'(LAT_LEN)) begin
                                n_lat  = {r_lat[LAT_W-9:0], i_in_char};
                                n_flen = r_flen + 4'd1;
                                if (r_flen == 4'(LAT_LEN - 1)) begin
                                    n_lat_done = 1'b1;
                                end
                            end
                        end
                        FLD_NS: begin
                            if (r_flen == 4'd0) begin
                                n_ns   = i_in_char;
                                n_flen = 4'd1;
                            end
                        end
                        FLD_LON: begin
                            if (r_flen < 4'(LON_LEN)) begin
                                n_lon  = {r_lon[LON_W-9:0], i_in_char};
                                n_flen = r_flen + 4'd1;
                                if (r_flen == 4'(LON_LEN - 1)) begin
                                    n_lon_done = 1'b1;
                                end
                            end
                        end
                        FLD_EW: begin
                            if (r_flen == 4'd0) begin
                                n_ew   = i_in_char;
                                n_flen = 4'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    // Line verdict, taken with the final character included
    assign found = n_hdr_ok && (n_pos == 3'(HDR_LEN)) && n_lat_done && n_lon_done &&
                   ((n_ns == CH_N) || (n_ns == CH_S)) &&
                   ((n_ew == CH_E) || (n_ew == CH_W));

    // Line state registers; cleared on reset and after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || load) begin
            r_pos      <= 3'd0;
            r_hdr_ok   <= 1'b1;
            r_commas   <= 3'd0;
            r_flen     <= 4'd0;
            r_lat      <= '0;
            r_lon      <= '0;
            r_ns       <= 8'd0;
            r_ew       <= 8'd0;
            r_lat_done <= 1'b0;
            r_lon_done <= 1'b0;
            r_ended    <= 1'b0;
        end else if (acc) begin
            r_pos      <= n_pos;
            r_hdr_ok   <= n_hdr_ok;
            r_commas   <= n_commas;
            r_flen     <= n_flen;
            r_lat      <= n_lat;
            r_lon      <= n_lon;
            r_ns       <= n_ns;
            r_ew       <= n_ew;
            r_lat_done <= n_lat_done;
            r_lon_done <= n_lon_done;
            r_ended    <= n_ended;
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload; zeroed when no position was found
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_found <= found;
            r_lat_q <= found ? n_lat : '0;
            r_ns_q  <= found ? n_ns  : 8'd0;
            r_lon_q <= found ? n_lon : '0;
            r_ew_q  <= found ? n_ew  : 8'd0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_lat_digits = r_lat_q;
    assign o_ns_letter  = r_ns_q;
    assign o_lon_digits = r_lon_q;
    assign o_ew_letter  = r_ew_q;

    // Checks
    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_is_last) |=> o_out_valid)
        else $error("final character did not produce a result");

    a_found_hemi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |->
        ((o_ns_letter == CH_N || o_ns_letter == CH_S) &&
         (o_ew_letter == CH_E || o_ew_letter == CH_W)))
        else $error("found result with bad hemisphere letter");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |->
        (o_lat_digits == '0 && o_lon_digits == '0 && o_ns_letter == 8'd0 &&
         o_ew_letter == 8'd0))
        else $error("result without position carries data");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

endmodule

>>> test/gga_fix_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the GGA extractor: per-character line tracker and result checks.
package gga_fix_check_pkg;
    import gga_pfx_pkg::*;

    // Reference header; the talker letter may also be N
    localparam logic [8*HDR_LEN-1:0] GGA_HEADER = "$GPGGA";
    localparam int unsigned          TALKER_POS = 2;

    typedef struct packed {
        logic             found;
        logic [LAT_W-1:0] lat_digits;
        logic [7:0]       ns_letter;
        logic [LON_W-1:0] lon_digits;
        logic [7:0]       ew_letter;
    } t_gga_fix;

    class gga_fix_checker;
        // line state, cleared after every flagged character
        logic [2:0]       hdr_pos;
        bit               hdr_ok;
        logic [2:0]       commas;
        logic [3:0]       fld_len;
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
        logic [7:0]       ns;
        logic [7:0]       ew;
        bit               lat_full;
        bit               lon_full;
        bit               nul_seen;

        t_gga_fix    fix_queue[$];
        int unsigned fails;

        function new();
            fails = 0;
            restart_line();
        endfunction

        function void restart_line();
            hdr_pos  = '0;
            hdr_ok   = 1'b1;
            commas   = '0;
            fld_len  = '0;
            lat      = '0;
            lon      = '0;
            ns       = '0;
            ew       = '0;
            lat_full = 1'b0;
            lon_full = 1'b0;
            nul_seen = 1'b0;
        endfunction

        function int unsigned pending();
            return fix_queue.size();
        endfunction

        // Accepted request: advance the line state, queue a fix on the flagged character
        function void take_char(input logic [7:0] c, input logic last);
            t_gga_fix fix;
            bit       good;
            if (!nul_seen) begin
                if (c == CH_NUL) begin
                    nul_seen = 1'b1;
                end else begin
                    // header check over the first six characters
                    if (hdr_pos < HDR_LEN) begin
                        if (hdr_pos == TALKER_POS) begin
                            if (c != CH_P && c != CH_N)
                                hdr_ok = 1'b0;
                        end else if (c != GGA_HEADER[8*(HDR_LEN-1-hdr_pos) +: 8]) begin
                            hdr_ok = 1'b0;
                        end
                        hdr_pos++;
                    end
                    // field capture
                    if (c == CH_COMMA) begin
                        if (commas < COMMA_MAX)
                            commas++;
                        fld_len = '0;
                    end else begin
                        case (commas)
                            FLD_LAT: begin
                                if (fld_len < LAT_LEN) begin
                                    lat = {lat[LAT_W-9:0], c};
                                    fld_len++;
                                    if (fld_len == LAT_LEN)
                                        lat_full = 1'b1;
                                end
                            end
                            FLD_NS: begin
                                if (fld_len == 0) begin
                                    ns      = c;
                                    fld_len = 4'd1;
                                end
                            end
                            FLD_LON: begin
                                if (fld_len < LON_LEN) begin
                                    lon = {lon[LON_W-9:0], c};
                                    fld_len++;
                                    if (fld_len == LON_LEN)
                                        lon_full = 1'b1;
                                end
                            end
                            FLD_EW: begin
                                if (fld_len == 0) begin
                                    ew      = c;
                                    fld_len = 4'd1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            if (last) begin
                good = hdr_ok && (hdr_pos == HDR_LEN) && lat_full && lon_full &&
                       (ns == CH_N || ns == CH_S) && (ew == CH_E || ew == CH_W);
                fix = '0;
                if (good) begin
                    fix.found      = 1'b1;
                    fix.lat_digits = lat;
                    fix.ns_letter  = ns;
                    fix.lon_digits = lon;
                    fix.ew_letter  = ew;
                end
                fix_queue.push_back(fix);
                restart_line();
            end
        endfunction

        function void compare_field(input string field, input logic [63:0] want,
                                    input logic [63:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
                fails++;
            end
        endfunction

        // Accepted result: compare against the oldest queued fix
        function void check_fix(input t_gga_fix got);
            t_gga_fix want;
            if (fix_queue.size() == 0) begin
                $error("result with no line pending: found=%0b", got.found);
                fails++;
                return;
            end
            want = fix_queue.pop_front();
            compare_field("found", want.found, got.found);
            compare_field("lat_digits", want.lat_digits, got.lat_digits);
            compare_field("ns_letter", want.ns_letter, got.ns_letter);
            compare_field("lon_digits", want.lon_digits, got.lon_digits);
            compare_field("ew_letter", want.ew_letter, got.ew_letter);
        endfunction
    endclass

endpackage

>>> test/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench: drives NMEA lines into the GGA extractor and checks every fix.
module testbench;
    import gga_pfx_pkg::*;
    import gga_fix_check_pkg::*;

    localparam int unsigned LINE_CHARS      = 1600;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned DRAIN_LIMIT     = 5000;
    localparam int unsigned WATCHDOG_NS     = 5_000_000;
    localparam logic [7:0]  CH_ZERO         = "0";
    localparam logic [7:0]  CH_DOT          = ".";

    typedef enum int unsigned {
        SHAPE_NOISE, SHAPE_SHORT, SHAPE_BAD_HEADER, SHAPE_ODD_LAT, SHAPE_ODD_LON, SHAPE_CLEAN
    } t_line_shape;

    typedef enum int unsigned { RX_FREE, RX_RANDOM, RX_PATTERN, RX_HEAVY } t_rx_mode;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [7:0]       i_in_char;
    logic             i_is_last;
    logic             o_out_valid;
    logic             i_out_stall;
    logic             o_found;
    logic [LAT_W-1:0] o_lat_digits;
    logic [7:0]       o_ns_letter;
    logic [LON_W-1:0] o_lon_digits;
    logic [7:0]       o_ew_letter;

    gga_fix_checker fix_check;
    logic [7:0]     line_buf[$];
    int unsigned    burst_left;
    int unsigned    counted;

    gga_position_field_extractor_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_char    (i_in_char),
        .i_is_last    (i_is_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_found      (o_found),
        .o_lat_digits (o_lat_digits),
        .o_ns_letter  (o_ns_letter),
        .o_lon_digits (o_lon_digits),
        .o_ew_letter  (o_ew_letter)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both channels sampled at the rising edge
    always @(posedge i_clk) begin : watch
        t_gga_fix seen;
        if (i_rst_n && i_in_valid && !o_in_stall)
            fix_check.take_char(i_in_char, i_is_last);
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.found      = o_found;
            seen.lat_digits = o_lat_digits;
            seen.ns_letter  = o_ns_letter;
            seen.lon_digits = o_lon_digits;
            seen.ew_letter  = o_ew_letter;
            fix_check.check_fix(seen);
        end
    end

    // One request; a gap of idle cycles opens whenever a burst runs out
    task automatic send_char(input logic [7:0] c, input logic last);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 6)) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                      : $urandom_range(1, 20);
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_char  <= c;
        i_is_last  <= last;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
    endtask

    // Sends line_buf, flag on the final character; characters after a NUL are not counted
    task automatic send_line();
        bit nul_hit;
        nul_hit = 1'b0;
        foreach (line_buf[i]) begin
            if (!nul_hit)
                counted++;
            if (line_buf[i] == CH_NUL)
                nul_hit = 1'b1;
            send_char(line_buf[i], i == line_buf.size() - 1);
        end
    endtask

    function automatic void push_text(input string s);
        foreach (s[i])
            line_buf.push_back(s[i]);
    endfunction

    // Mostly digits and dots, now and then any byte at all
    function automatic void push_digits(input int unsigned n);
        repeat (n) begin
            if ($urandom_range(0, 15) == 0)
                line_buf.push_back(8'($urandom_range(0, 255)));
            else if ($urandom_range(0, 7) == 0)
                line_buf.push_back(CH_DOT);
            else
                line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endfunction

    // Hemisphere field: usually a good letter, sometimes empty, junk or overlong
    function automatic void push_hemi(input logic [7:0] a, input logic [7:0] b);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 1) begin
            line_buf.push_back(8'($urandom_range(0, 255)));
        end else if (r == 2) begin
            line_buf.push_back(a);
            push_digits($urandom_range(1, 3));
        end else if (r != 0) begin
            line_buf.push_back($urandom_range(0, 1) ? a : b);
        end
    endfunction

    function automatic int unsigned field_len(input int unsigned nominal, input bit odd);
        if (odd)
            return $urandom_range(0, nominal + 3);
        if ($urandom_range(0, 3) == 0)
            return nominal + $urandom_range(0, 3);
        return nominal;
    endfunction

    function automatic void build_line();
        int unsigned r;
        t_line_shape shape;
        line_buf.delete();
        r = $urandom_range(0, 19);
        shape = (r > SHAPE_CLEAN) ? SHAPE_CLEAN : t_line_shape'(r);

        if (shape == SHAPE_NOISE) begin
            repeat ($urandom_range(1, 40))
                line_buf.push_back(8'($urandom_range(0, 255)));
        end else begin
            // header, talker letter P or N
            for (int unsigned p = 0; p < HDR_LEN; p++)
                line_buf.push_back(p == TALKER_POS ? ($urandom_range(0, 1) ? CH_P : CH_N)
                                                   : GGA_HEADER[8*(HDR_LEN-1-p) +: 8]);
            if (shape == SHAPE_SHORT) begin
                line_buf = line_buf[0:$urandom_range(0, HDR_LEN - 2)];
            end else begin
                if (shape == SHAPE_BAD_HEADER)
                    line_buf[$urandom_range(0, HDR_LEN - 1)] = 8'($urandom_range(0, 255));
                line_buf.push_back(CH_COMMA);
                push_digits($urandom_range(0, 10));
                line_buf.push_back(CH_COMMA);
                push_digits(field_len(LAT_LEN, shape == SHAPE_ODD_LAT));
                line_buf.push_back(CH_COMMA);
                push_hemi(CH_N, CH_S);
                line_buf.push_back(CH_COMMA);
                push_digits(field_len(LON_LEN, shape == SHAPE_ODD_LON));
                line_buf.push_back(CH_COMMA);
                push_hemi(CH_E, CH_W);
                // trailing fields drive the comma count into saturation
                repeat ($urandom_range(0, 5)) begin
                    line_buf.push_back(CH_COMMA);
                    push_digits($urandom_range(0, 6));
                end
            end
        end

        // an early NUL ends the content of the line
        if ($urandom_range(0, 9) == 0)
            line_buf[$urandom_range(0, line_buf.size() - 1)] = CH_NUL;
    endfunction

    // Receiver: stall patterns that change from segment to segment, one long hold-off
    initial begin : receiver
        int unsigned seg;
        int unsigned span;
        int unsigned period;
        t_rx_mode    mode;
        i_out_stall = 1'b0;
        seg = 0;
        @(posedge i_rst_n);
        forever begin
            seg++;
            if (seg == 6) begin
                // long hold-off: result register stays full and the input backs up
                repeat (HOLD_OFF_CYCLES) begin
                    @(negedge i_clk);
                    i_out_stall <= 1'b1;
                end
            end
            span   = $urandom_range(20, 150);
            mode   = t_rx_mode'($urandom_range(RX_FREE, RX_HEAVY));
            period = $urandom_range(2, 5);
            for (int unsigned n = 0; n < span; n++) begin
                @(negedge i_clk);
                case (mode)
                    RX_FREE:    i_out_stall <= 1'b0;
                    RX_RANDOM:  i_out_stall <= 1'($urandom_range(0, 1));
                    RX_PATTERN: i_out_stall <= (n % period) == 0;
                    RX_HEAVY:   i_out_stall <= $urandom_range(0, 4) != 0;
                    default:    i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // Stimulus and end of run
    initial begin : stimulus
        int unsigned waited;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_char  = '0;
        i_is_last  = 1'b0;
        fix_check  = new();
        burst_left = 0;
        counted    = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-ones byte alone, NUL alone, then a valid line at the field extremes
        line_buf = '{8'hFF};
        send_line();
        line_buf = '{CH_NUL};
        send_line();
        line_buf.delete();
        push_text("$GNGGA,,9959.99,S,17959.99,W");
        send_line();

        // random lines
        while (counted < LINE_CHARS) begin
            build_line();
            send_line();
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // drain outstanding results, then report the verdict
        waited = 0;
        while (fix_check.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (fix_check.fails == 0 && fix_check.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("simulation failed");
        $finish;
    end

endmodule

>>> files.f
src/gga_pfx_pkg.sv
src/gga_position_field_extractor_unit.sv
test/gga_fix_check_pkg.sv
test/testbench.sv
